/* hw/rtl/lbm_pkg.sv */
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared constants and types of the label boundary mask block: frame limits,
// label and counter widths, register indexes and the result item.
// ----------------------------------------------------------------------------
package lbm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int LABEL_BITS  = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);

    localparam int LABEL_FIELD_BITS = 16;
    localparam int WIDTH_BITS       = 11;
    localparam int HEIGHT_BITS      = 12;
    localparam int CFG_DATA_BITS    = 12;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [LABEL_BITS-1:0]    label_t;
    typedef logic [COL_BITS-1:0]      col_t;
    typedef logic [COL_BITS:0]        span_t;
    typedef logic [WIDTH_BITS-1:0]    frame_width_t;
    typedef logic [HEIGHT_BITS-1:0]   row_t;
    typedef logic                     cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

    localparam cfg_idx_t CFG_FRAME_WIDTH  = 1'b0;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic is_boundary;
        logic end_of_row;
        logic end_of_frame;
    } out_item_t;

endpackage

/* hw/rtl/lbm_if.sv */
// ----------------------------------------------------------------------------
// lbm_if
// Valid/ready channels of the label boundary mask block: the label pixel
// stream in and the boundary mask stream out.
// ----------------------------------------------------------------------------
interface lbm_in_if;
    import lbm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [LABEL_FIELD_BITS-1:0] label_value;

    modport source (output valid, output kind, output label_value, input ready);
    modport sink   (input valid, input kind, input label_value, output ready);
endinterface

interface lbm_out_if;
    logic valid;
    logic ready;
    logic is_boundary;
    logic end_of_row;
    logic end_of_frame;

    modport source (output valid, output is_boundary, output end_of_row,
                    output end_of_frame, input ready);
    modport sink   (input valid, input is_boundary, input end_of_row,
                    input end_of_frame, output ready);
endinterface

/* hw/rtl/lbm_ram.sv */
// ----------------------------------------------------------------------------
// lbm_ram
// Simple dual-port line buffer: one write and one registered read per cycle,
// read data holds while no read is issued.
// ----------------------------------------------------------------------------
module lbm_ram #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);
    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/lbm_out_stage.sv */
// ----------------------------------------------------------------------------
// lbm_out_stage
// Result register with a one-entry skid stage; room is registered so the
// input side never waits on the output handshake combinationally.
// ----------------------------------------------------------------------------
module lbm_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lbm_pkg::out_item_t push_data,
    output logic              room,
    lbm_out_if.source         mask
);
    import lbm_pkg::*;

    logic      out_vld_reg, out_vld_next;
    logic      skid_vld_reg, skid_vld_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      take;

    assign take = out_vld_reg && mask.ready;

    always_comb
    begin
        out_vld_next   = out_vld_reg;
        skid_vld_next  = skid_vld_reg;
        out_data_next  = out_data_reg;
        skid_data_next = skid_data_reg;
        if (push)
        begin
            if (out_vld_reg && !take)
            begin
                skid_data_next = push_data;
                skid_vld_next  = 1'b1;
            end
            else
            begin
                out_data_next = push_data;
                out_vld_next  = 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_vld_reg)
            begin
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room              = !skid_vld_reg;
    assign mask.valid        = out_vld_reg;
    assign mask.is_boundary  = out_data_reg.is_boundary;
    assign mask.end_of_row   = out_data_reg.end_of_row;
    assign mask.end_of_frame = out_data_reg.end_of_frame;

    // no push without a free slot
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("result pushed with skid stage full");

    // skid holds data only behind a waiting result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage valid without output valid");

    // a result pushed under stall moves to the skid stage, never lost
    a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !mask.ready && push) |=> (out_vld_reg && skid_vld_reg))
        else $error("result dropped under stall");
endmodule

/* hw/rtl/label_boundary_mask_core.sv */
// ----------------------------------------------------------------------------
// label_boundary_mask_core
// 4-neighbour boundary mask of a raster label stream using two line buffers
// that swap roles at each row end; a sliding centre-row window fed one read
// ahead from the line buffers supplies left, centre and right labels.
// A result enters the output stage on the transfer of the pixel below it (or
// of the drain tick for the last row). Throughput: 1 item per cycle unless
// the skid stage is full, set by one read and one write per line buffer.
// Reset: counters and role clear, frame_width 640, frame_height 480; line
//   buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module label_boundary_mask_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  lbm_pkg::cfg_idx_t  cfg_index,
    input  lbm_pkg::cfg_data_t cfg_wdata,
    lbm_in_if.sink             pixel,
    lbm_out_if.source          mask
);
    import lbm_pkg::*;

    frame_width_t width_reg, width_next;
    row_t         height_reg, height_next;
    col_t         col_reg, col_next;
    row_t         row_reg, row_next;
    logic         role_reg, role_next;
    col_t         drain_reg, drain_next;
    logic         fwd_sel_reg, fwd_sel_next;

    label_t win_prev_reg, win_prev_next;
    label_t win_cur_reg, win_cur_next;
    label_t first_wr_reg, first_wr_next;
    label_t first_cen_reg, first_cen_next;
    label_t first_up_reg, first_up_next;
    label_t fwd_lab_reg, fwd_lab_next;

    span_t     eff_w;
    row_t      eff_h;
    logic      room;
    logic      in_fire;
    logic      draining;
    logic      is_pix;
    logic      take_pix;
    logic      take_drain;
    logic      active;
    logic      emit;
    col_t      pos;
    logic      last_col;
    label_t    lab;
    label_t    rd_above;
    label_t    rd_centre;
    label_t    cen_rd;
    label_t    up_rd;
    label_t    cen_r;
    label_t    up_v;
    logic      has_up;
    logic      boundary;
    logic      re_cen;
    logic      re_up;
    col_t      addr_cen;
    col_t      addr_up;
    out_item_t result;

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = span_t'(1);
        end
        else if (span_t'(width_reg) > span_t'(MAX_WIDTH) || width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            eff_w = span_t'(MAX_WIDTH);
        end
        else
        begin
            eff_w = span_t'(width_reg);
        end
        eff_h = (height_reg == '0) ? row_t'(1) : height_reg;
    end

    assign pixel.ready = room;
    assign in_fire     = pixel.valid && room;
    assign draining    = row_reg >= eff_h;
    assign is_pix      = pixel.kind == KIND_PIXEL;
    assign lab         = LABEL_BITS'(pixel.label_value);
    assign take_pix    = in_fire && is_pix && !draining && !cfg_we;
    assign take_drain  = in_fire && (pixel.kind == KIND_DRAIN) && draining && !cfg_we;
    assign active      = take_pix || take_drain;
    assign emit        = take_drain || (take_pix && row_reg != '0);
    assign pos         = is_pix ? col_reg : drain_reg;
    assign last_col    = (span_t'(pos) + span_t'(1)) == eff_w;

    // neighbour labels
    assign cen_rd   = role_reg ? rd_above : rd_centre;
    assign up_rd    = role_reg ? rd_centre : rd_above;
    assign cen_r    = fwd_sel_reg ? fwd_lab_reg : cen_rd;
    assign up_v     = (pos == '0) ? first_up_reg : up_rd;
    assign has_up   = is_pix ? (row_reg >= row_t'(2)) : (eff_h >= row_t'(2));
    assign boundary = (has_up && up_v != win_cur_reg)
                   || (is_pix && lab != win_cur_reg)
                   || (pos != '0 && win_prev_reg != win_cur_reg)
                   || (!last_col && cen_r != win_cur_reg);

    assign result = '{is_boundary: boundary, end_of_row: last_col,
                      end_of_frame: take_drain && last_col};

    // read-ahead addresses
    assign re_cen   = active && !last_col;
    assign addr_cen = pos + col_t'(2);
    assign re_up    = active;
    assign addr_up  = (take_pix && last_col) ? col_t'(1) : pos + col_t'(1);

    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        role_next      = role_reg;
        drain_next     = drain_reg;
        fwd_sel_next   = fwd_sel_reg;
        win_prev_next  = win_prev_reg;
        win_cur_next   = win_cur_reg;
        first_wr_next  = first_wr_reg;
        first_cen_next = first_cen_reg;
        first_up_next  = first_up_reg;
        fwd_lab_next   = fwd_lab_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_next  = cfg_wdata[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: height_next = cfg_wdata[HEIGHT_BITS-1:0];
            endcase
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
        end
        else if (take_pix)
        begin
            if (col_reg == '0)
            begin
                first_wr_next = lab;
            end
            if (last_col)
            begin
                col_next       = '0;
                row_next       = row_reg + row_t'(1);
                role_next      = !role_reg;
                drain_next     = '0;
                first_up_next  = first_cen_reg;
                first_cen_next = (col_reg == '0) ? lab : first_wr_reg;
                win_cur_next   = (col_reg == '0) ? lab : first_wr_reg;
                fwd_sel_next   = eff_w == span_t'(2);
                fwd_lab_next   = lab;
            end
            else
            begin
                col_next      = col_reg + col_t'(1);
                win_prev_next = win_cur_reg;
                win_cur_next  = cen_r;
                fwd_sel_next  = 1'b0;
            end
        end
        else if (take_drain)
        begin
            if (last_col)
            begin
                drain_next = '0;
                row_next   = '0;
                col_next   = '0;
            end
            else
            begin
                drain_next    = drain_reg + col_t'(1);
                win_prev_next = win_cur_reg;
                win_cur_next  = cen_r;
                fwd_sel_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            role_reg    <= 1'b0;
            drain_reg   <= '0;
            fwd_sel_reg <= 1'b0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            role_reg    <= role_next;
            drain_reg   <= drain_next;
            fwd_sel_reg <= fwd_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_prev_reg  <= win_prev_next;
        win_cur_reg   <= win_cur_next;
        first_wr_reg  <= first_wr_next;
        first_cen_reg <= first_cen_next;
        first_up_reg  <= first_up_next;
        fwd_lab_reg   <= fwd_lab_next;
    end

    lbm_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (LABEL_BITS)
    ) u_ram_above (
        .clk   (clk),
        .we    (take_pix && !role_reg),
        .waddr (col_reg),
        .wdata (lab),
        .re    (role_reg ? re_cen : re_up),
        .raddr (role_reg ? addr_cen : addr_up),
        .rdata (rd_above)
    );

    lbm_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (LABEL_BITS)
    ) u_ram_centre (
        .clk   (clk),
        .we    (take_pix && role_reg),
        .waddr (col_reg),
        .wdata (lab),
        .re    (role_reg ? re_up : re_cen),
        .raddr (role_reg ? addr_up : addr_cen),
        .rdata (rd_centre)
    );

    lbm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (result),
        .room      (room),
        .mask      (mask)
    );

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        span_t'(col_reg) < eff_w)
        else $error("column count beyond frame width");

    a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
        span_t'(drain_reg) < eff_w)
        else $error("drain count beyond frame width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= eff_h)
        else $error("row count beyond frame height");

    a_role_swap: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(role_reg) |-> $past(take_pix && last_col))
        else $error("line buffer roles swapped outside a row end");
endmodule
